>>> hdl/b3lp_pkg.sv
// Package for the third-order Butterworth lowpass: formats, constants, sequencer states,
// the divider control struct and the round-half-up shift helper.
// No dependencies; every other file in hdl imports it.
package b3lp_pkg;

   // Field widths and fixed-point formats.
   localparam int SAMPLE_BITS    = 16;
   localparam int RATE_BITS      = 18;
   localparam int CUTOFF_BITS    = 17;
   localparam int COEF_FRAC_BITS = 28;
   localparam int K_FRAC_BITS    = 30;

   // Sample rate limits and reset value.
   localparam logic [RATE_BITS-1:0] FS_MIN   = RATE_BITS'(8000);
   localparam logic [RATE_BITS-1:0] FS_MAX   = RATE_BITS'(192000);
   localparam logic [RATE_BITS-1:0] FS_RESET = RATE_BITS'(48000);

   // Shared multiplier: signed operands, full product.
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   // pi in Q2.30.
   localparam logic signed [MUL_W-1:0] PI_Q30 = MUL_W'(64'd3373259426);

   // Datapath widths.
   localparam int K_W    = 31;   // k, k^2, k^3, all positive and below 2^30
   localparam int COEF_W = 34;   // coefficients a, b, c, d, signed
   localparam int SUM_W  = 20;   // x + 3*x1 + 3*x2 + x3
   localparam int ACC_W  = 40;   // feedback numerator
   localparam int Y_W    = 32;   // stored outputs, Q4.28

   // Shared divider: 64-bit dividend, 32-bit divisor, up to 36 quotient bits.
   localparam int DIVD_W = 64;
   localparam int DIVS_W = 32;
   localparam int QUOT_W = 36;
   localparam int CNT_W  = 6;
   localparam logic [CNT_W-1:0] K_QBITS = CNT_W'(31);
   localparam logic [CNT_W-1:0] Y_QBITS = CNT_W'(QUOT_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_PI,
      ST_DIV_K,
      ST_WAIT_K,
      ST_MUL_K2,
      ST_MUL_K3,
      ST_MUL_X,
      ST_MUL_B,
      ST_MUL_C,
      ST_MUL_D,
      ST_SUM,
      ST_DIV_Y,
      ST_WAIT_Y,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] qbits;
   } div_ctrl_type;

   // Adds half an LSB of the result, then shifts right arithmetically.
   function automatic logic signed [PROD_W-1:0] shr_round(
      input logic signed [PROD_W-1:0] v,
      input int unsigned              s
   );
      logic signed [PROD_W-1:0] half;
      half = $signed(PROD_W'(1) << (s - 1));
      return (v + half) >>> s;
   endfunction

endpackage

>>> hdl/b3lp_mul.sv
// Shared signed multiplier of the Butterworth lowpass, product registered.
// Depends on b3lp_pkg for the operand and product widths.
module b3lp_mul (
   input  logic                              clock,
   input  logic signed [b3lp_pkg::MUL_W-1:0]  mul_a,
   input  logic signed [b3lp_pkg::MUL_W-1:0]  mul_b,
   output logic signed [b3lp_pkg::PROD_W-1:0] prod
);
   import b3lp_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> hdl/b3lp_div.sv
// Shared restoring divider of the Butterworth lowpass, one quotient bit per cycle.
// Depends on b3lp_pkg for widths and the control struct.
module b3lp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  b3lp_pkg::div_ctrl_type            ctrl,
   input  logic [b3lp_pkg::DIVD_W-1:0]       dividend,
   input  logic [b3lp_pkg::DIVS_W-1:0]       divisor,
   output logic                              done,
   output logic [b3lp_pkg::QUOT_W-1:0]       quot
);
   import b3lp_pkg::*;

   localparam int SH_W = $clog2(DIVD_W) + 1;

   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] lo_ff, lo_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [DIVS_W-1:0] divisor_ff, divisor_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVS_W+1:0] trial;

   // The caller guarantees the quotient fits in qbits, so the bits above them
   // form a starting remainder that is already below the divisor.
   always_comb begin
      rem_in     = rem_ff;
      lo_in      = lo_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      trial      = {1'b0, rem_ff, lo_ff[DIVD_W-1]} - {2'b00, divisor_ff};
      if (ctrl.start) begin
         rem_in     = DIVS_W'(dividend >> ctrl.qbits);
         lo_in      = dividend << (SH_W'(DIVD_W) - SH_W'(ctrl.qbits));
         quot_in    = '0;
         divisor_in = divisor;
         cnt_in     = ctrl.qbits;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIVS_W+1]) begin
            rem_in  = trial[DIVS_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[DIVS_W-2:0], lo_ff[DIVD_W-1]};
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
         lo_in  = lo_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      lo_ff      <= lo_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> hdl/butterworth3_lowpass_iir.sv
// Third-order Butterworth lowpass (bilinear transform) with a per-sample cutoff.
// Top level: sequencer, coefficient and feedback datapath, configuration register.
// Depends on b3lp_pkg, b3lp_mul and b3lp_div.
//
// Each request carries a Q1.15 sample and a cutoff in Hz; the block recomputes
// k = pi*fc/fs and the filter coefficients for every sample and returns one
// saturated Q1.15 sample per request. The sample rate register is clamped to
// 8000..192000 Hz when used, and the cutoff to 1..fs/2. The block works on one
// request at a time: req_stall stays high until its result is in the response
// register. Most of a transaction is spent in the two divisions through the
// single bit-serial divider (31 quotient bits for k, 36 for the output), and
// the seven products share one registered multiplier. Write the sample rate only
// while no request is in flight. A finished response waits in its own register,
// so the next request is accepted while the response is still stalled.
module butterworth3_lowpass_iir (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [b3lp_pkg::SAMPLE_BITS-1:0]  req_sample_in,
   input  logic [b3lp_pkg::CUTOFF_BITS-1:0]         req_cutoff_hz,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [b3lp_pkg::SAMPLE_BITS-1:0]  rsp_sample_out,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [b3lp_pkg::RATE_BITS-1:0]           csr_sample_rate_hz
);
   import b3lp_pkg::*;

   localparam int YF_W = QUOT_W + 1;
   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;
   localparam logic signed [YF_W-1:0]   Y_MAX    = YF_W'((64'd1 << (Y_W - 1)) - 64'd1);
   localparam logic signed [YF_W-1:0]   Y_MIN    = -Y_MAX - YF_W'(1);
   localparam logic signed [PROD_W-1:0] O_MAX    =
      PROD_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [PROD_W-1:0] O_MIN    = -O_MAX - PROD_W'(1);

   state_type state_ff, state_in;

   logic [RATE_BITS-1:0]          rate_ff, rate_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [CUTOFF_BITS-1:0]        fc_ff, fc_in;
   logic signed [SAMPLE_BITS-1:0] past_in_1_ff, past_in_1_in;
   logic signed [SAMPLE_BITS-1:0] past_in_2_ff, past_in_2_in;
   logic signed [SAMPLE_BITS-1:0] past_in_3_ff, past_in_3_in;
   logic signed [Y_W-1:0]         past_out_1_ff, past_out_1_in;
   logic signed [Y_W-1:0]         past_out_2_ff, past_out_2_in;
   logic signed [Y_W-1:0]         past_out_3_ff, past_out_3_in;
   logic [K_W-1:0]                k_ff, k_in;
   logic [K_W-1:0]                k2_ff, k2_in;
   logic [K_W-1:0]                k3_ff, k3_in;
   logic [COEF_W-1:0]             a_ff, a_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic                          neg_ff, neg_in;
   logic signed [SAMPLE_BITS-1:0] res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out_ff, rsp_sample_out_in;

   logic [RATE_BITS-1:0]     fs_c;
   logic [CUTOFF_BITS-1:0]   half_fs;
   logic [CUTOFF_BITS-1:0]   fc_clamp;
   logic signed [SUM_W-1:0]  pair_sum;
   logic signed [SUM_W-1:0]  s_c;
   logic signed [COEF_W-1:0] kc, k2c, k3c;
   logic signed [COEF_W-1:0] a_c, b_c, c_c, d_c;
   logic [K_W-1:0]           k2_rnd, k3_rnd;
   logic [ACC_W-1:0]         n_mag;
   logic signed [YF_W-1:0]   y_full;
   logic signed [Y_W-1:0]    y_sat;
   logic signed [PROD_W-1:0] o_full;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   div_ctrl_type             div_ctrl;
   logic [DIVD_W-1:0]        div_dividend;
   logic [DIVS_W-1:0]        div_divisor;
   logic                     div_done;
   logic [QUOT_W-1:0]        div_quot;

   b3lp_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   b3lp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot)
   );

   // Operand preparation shared by several sequencer states.
   always_comb begin
      if (rate_ff < FS_MIN) begin
         fs_c = FS_MIN;
      end else if (rate_ff > FS_MAX) begin
         fs_c = FS_MAX;
      end else begin
         fs_c = rate_ff;
      end
      half_fs = fs_c[RATE_BITS-1:1];
      if (req_cutoff_hz == '0) begin
         fc_clamp = CUTOFF_BITS'(1);
      end else if (req_cutoff_hz > half_fs) begin
         fc_clamp = half_fs;
      end else begin
         fc_clamp = req_cutoff_hz;
      end

      pair_sum = SUM_W'(past_in_1_ff) + SUM_W'(past_in_2_ff);
      s_c      = SUM_W'(x_ff) + pair_sum + (pair_sum <<< 1) + SUM_W'(past_in_3_ff);

      kc  = COEF_W'(k_ff);
      k2c = COEF_W'(k2_ff);
      k3c = COEF_W'(k3_ff);
      a_c = COEF_ONE + (kc <<< 1) + (k2c <<< 1) + k3c;
      b_c = (COEF_ONE <<< 1) + COEF_ONE + (kc <<< 1) - (k2c <<< 1) - ((k3c <<< 1) + k3c);
      c_c = (kc <<< 1) + (k2c <<< 1) - ((COEF_ONE <<< 1) + COEF_ONE)
            - ((k3c <<< 1) + k3c);
      d_c = COEF_ONE - (kc <<< 1) + (k2c <<< 1) - k3c;

      k2_rnd = K_W'(shr_round(prod, COEF_FRAC_BITS));
      k3_rnd = K_W'(shr_round(prod, COEF_FRAC_BITS));

      n_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

      y_full = neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
      if (y_full > Y_MAX) begin
         y_sat = Y_W'(Y_MAX);
      end else if (y_full < Y_MIN) begin
         y_sat = Y_W'(Y_MIN);
      end else begin
         y_sat = Y_W'(y_full);
      end
      o_full = shr_round(PROD_W'(y_sat), COEF_FRAC_BITS - (SAMPLE_BITS - 1));
   end

   // Sequencer: next state, operand selection and register updates.
   always_comb begin
      state_in          = state_ff;
      rate_in           = rate_ff;
      x_in              = x_ff;
      fc_in             = fc_ff;
      past_in_1_in      = past_in_1_ff;
      past_in_2_in      = past_in_2_ff;
      past_in_3_in      = past_in_3_ff;
      past_out_1_in     = past_out_1_ff;
      past_out_2_in     = past_out_2_ff;
      past_out_3_in     = past_out_3_ff;
      k_in              = k_ff;
      k2_in             = k2_ff;
      k3_in             = k3_ff;
      a_in              = a_ff;
      acc_in            = acc_ff;
      neg_in            = neg_ff;
      res_in            = res_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_sample_out_in = rsp_sample_out_ff;
      mul_a             = '0;
      mul_b             = '0;
      div_ctrl.start    = 1'b0;
      div_ctrl.qbits    = K_QBITS;
      div_dividend      = DIVD_W'(prod) + DIVD_W'(half_fs);
      div_divisor       = DIVS_W'(fs_c);

      if (csr_valid) begin
         rate_in = csr_sample_rate_hz;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               fc_in    = fc_clamp;
               state_in = ST_MUL_PI;
            end
         end
         ST_MUL_PI: begin
            mul_a    = PI_Q30;
            mul_b    = MUL_W'(fc_ff);
            state_in = ST_DIV_K;
         end
         ST_DIV_K: begin
            // k in Q2.30 = round(pi * fc / fs).
            div_ctrl.start = 1'b1;
            state_in       = ST_WAIT_K;
         end
         ST_WAIT_K: begin
            if (div_done) begin
               k_in     = K_W'(shr_round(PROD_W'(div_quot), K_FRAC_BITS - COEF_FRAC_BITS));
               state_in = ST_MUL_K2;
            end
         end
         ST_MUL_K2: begin
            mul_a    = MUL_W'(k_ff);
            mul_b    = MUL_W'(k_ff);
            state_in = ST_MUL_K3;
         end
         ST_MUL_K3: begin
            k2_in    = k2_rnd;
            mul_a    = MUL_W'(k2_rnd);
            mul_b    = MUL_W'(k_ff);
            state_in = ST_MUL_X;
         end
         ST_MUL_X: begin
            k3_in    = k3_rnd;
            mul_a    = MUL_W'(k3_rnd);
            mul_b    = MUL_W'(s_c);
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            acc_in   = ACC_W'(shr_round(prod, SAMPLE_BITS - 1));
            a_in     = a_c;
            mul_a    = MUL_W'(b_c);
            mul_b    = MUL_W'(past_out_1_ff);
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            acc_in   = acc_ff + ACC_W'(shr_round(prod, COEF_FRAC_BITS));
            mul_a    = MUL_W'(c_c);
            mul_b    = MUL_W'(past_out_2_ff);
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            acc_in   = acc_ff + ACC_W'(shr_round(prod, COEF_FRAC_BITS));
            mul_a    = MUL_W'(d_c);
            mul_b    = MUL_W'(past_out_3_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in   = acc_ff + ACC_W'(shr_round(prod, COEF_FRAC_BITS));
            state_in = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            // Dividing the magnitude with half the divisor added rounds half away
            // from zero once the sign is put back.
            neg_in         = acc_ff[ACC_W-1];
            div_ctrl.start = 1'b1;
            div_ctrl.qbits = Y_QBITS;
            div_dividend   = (DIVD_W'(n_mag) << COEF_FRAC_BITS) + DIVD_W'(a_ff >> 1);
            div_divisor    = DIVS_W'(a_ff);
            state_in       = ST_WAIT_Y;
         end
         ST_WAIT_Y: begin
            if (div_done) begin
               past_in_3_in  = past_in_2_ff;
               past_in_2_in  = past_in_1_ff;
               past_in_1_in  = x_ff;
               past_out_3_in = past_out_2_ff;
               past_out_2_in = past_out_1_ff;
               past_out_1_in = y_sat;
               if (o_full > O_MAX) begin
                  res_in = SAMPLE_BITS'(O_MAX);
               end else if (o_full < O_MIN) begin
                  res_in = SAMPLE_BITS'(O_MIN);
               end else begin
                  res_in = SAMPLE_BITS'(o_full);
               end
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_sample_out_in = res_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff       <= FS_RESET;
         rsp_valid_ff  <= 1'b0;
         past_in_1_ff  <= '0;
         past_in_2_ff  <= '0;
         past_in_3_ff  <= '0;
         past_out_1_ff <= '0;
         past_out_2_ff <= '0;
         past_out_3_ff <= '0;
      end else begin
         rate_ff       <= rate_in;
         rsp_valid_ff  <= rsp_valid_in;
         past_in_1_ff  <= past_in_1_in;
         past_in_2_ff  <= past_in_2_in;
         past_in_3_ff  <= past_in_3_in;
         past_out_1_ff <= past_out_1_in;
         past_out_2_ff <= past_out_2_in;
         past_out_3_ff <= past_out_3_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff              <= x_in;
      fc_ff             <= fc_in;
      k_ff              <= k_in;
      k2_ff             <= k2_in;
      k3_ff             <= k3_in;
      a_ff              <= a_in;
      acc_ff            <= acc_in;
      neg_ff            <= neg_in;
      res_ff            <= res_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign csr_ready      = 1'b1;

endmodule
